// ===== rtl/sv39w_pkg.sv =====
// Shared constants, codes and handshake structs of the Sv39 map and lookup walker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sv39w_pkg;

    localparam int TABLE_PAGES_DEF  = 64;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int IDX_W            = 9;
    localparam int VA_W             = 39;
    localparam int PA_W             = 56;
    localparam int PPN_W            = 44;
    localparam int PROT_W           = 10;
    localparam int ENTRY_W          = 64;
    localparam int STATUS_W         = 2;
    localparam int PTE_PPN_LSB      = 10;
    localparam int PAGE_SHIFT       = 12;

    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_MAPPED = 2'd1,
        ST_NO_PAGE    = 2'd2
    } t_status;

    // Access control from the walker to the table store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_stamp;
    } t_mem_ctl;

    // Registered read word: entry data plus the page-take stamp it was written with.
    typedef struct packed {
        logic               stamp;
        logic [ENTRY_W-1:0] data;
    } t_mem_rsp;

endpackage

`default_nettype wire

// ===== rtl/sv39_map_and_lookup_walker_unit.sv =====
// Top level of the Sv39 map and lookup walker: config register, walker, table store.
// Depends on sv39w_pkg, sv39w_store and sv39w_walk.
`default_nettype none

// Sv39 map and lookup walker. The block owns TABLE_PAGES table pages of 512
// 64-bit entries; page 0 is the root and page p sits at physical page number
// table_base_ppn + p. Raise i_start with an item while o_busy is low; the item
// is taken at that edge. A map (i_op = 0) walks levels 2 and 1, takes fresh
// zeroed pages where entries are invalid and writes the leaf at level 0; it is
// all or nothing and reports "no free table page" before writing anything. A
// lookup (i_op = 1) walks the same path and reports "not mapped" at the first
// invalid entry. Each item yields exactly one result, shown for one cycle with
// o_done high; there is no way to hold it off, so capture it on that edge.
// After reset the store is cleared one entry per cycle, all TABLE_PAGES * 512
// entries, with o_busy high. After that an item runs from the accepting edge to
// its o_done cycle thus: every table level that it walks costs a read on the
// single memory port, a map spends a decision state on page allocation, and
// each write back (up to three) takes the port once more. o_busy drops in the
// o_done cycle, so the next item may be started right then. Taking a page costs
// no clearing sweep: each entry carries a stamp telling whether its page was
// already taken when written, and a mismatch reads as zero. Write table_base_ppn
// only while the block is idle; the write channel is always ready.
module sv39_map_and_lookup_walker_unit
    import sv39w_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_op,
    input  wire logic [VA_W-1:0]       i_virt_addr,
    input  wire logic [PA_W-1:0]       i_phys_addr,
    input  wire logic [PROT_W-1:0]     i_prot_bits,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [ENTRY_W-1:0]         o_leaf_entry,
    output logic [PA_W-1:0]            o_entry_paddr,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [PPN_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(TABLE_PAGES) + IDX_W;

    logic [PPN_W-1:0]  r_base_ppn;
    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_mem_addr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    t_mem_rsp          w_mem_rsp;
    logic              w_clearing;

    // Base register: take every write; the channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ppn <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base_ppn <= i_cfg_data;
        end
    end

    // Sequencer: at most one store access per cycle, so reads never overlap writes.
    sv39w_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_op          (i_op),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_prot_bits   (i_prot_bits),
        .i_base_ppn    (r_base_ppn),
        .i_clearing    (w_clearing),
        .o_busy        (o_busy),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_leaf_entry  (o_leaf_entry),
        .o_entry_paddr (o_entry_paddr),
        .o_mem_ctl     (w_mem_ctl),
        .o_mem_addr    (w_mem_addr),
        .o_mem_wdata   (w_mem_wdata),
        .i_mem_rsp     (w_mem_rsp)
    );

    // Table store with registered read and the clearing pass after reset.
    sv39w_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mem_ctl),
        .i_addr     (w_mem_addr),
        .i_wdata    (w_mem_wdata),
        .o_rsp      (w_mem_rsp),
        .o_clearing (w_clearing)
    );

endmodule

`default_nettype wire

// ===== rtl/sv39w_store.sv =====
// Table store: single-port synchronous memory of all table pages with a clearing pass.
// Depends on sv39w_pkg.
`default_nettype none

module sv39w_store
    import sv39w_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire t_mem_ctl                                 i_ctl,
    input  wire logic [$clog2(TABLE_PAGES)+IDX_W-1:0]     i_addr,
    input  wire logic [ENTRY_W-1:0]                       i_wdata,
    output t_mem_rsp                                      o_rsp,
    output logic                                          o_clearing
);

    localparam int AW    = $clog2(TABLE_PAGES) + IDX_W;
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;

    t_mem_rsp          r_mem [DEPTH];
    t_mem_rsp          r_rd_word;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;

    logic              w_we;
    logic [AW-1:0]     w_addr;
    t_mem_rsp          w_word;

    // Clearing pass owns the write port until every entry is zero.
    assign w_we   = r_clearing | i_ctl.wr_en;
    assign w_addr = r_clearing ? r_clr_addr : i_addr;
    assign w_word = r_clearing ? '0 : t_mem_rsp'{stamp: i_ctl.wr_stamp, data: i_wdata};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_word;
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign o_rsp      = r_rd_word;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== rtl/sv39w_walk.sv =====
// Walk sequencer: issues store reads, checks entries, allocates pages, writes back.
// Depends on sv39w_pkg; drives sv39w_store.
`default_nettype none

module sv39w_walk
    import sv39w_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic                                 i_op,
    input  wire logic [VA_W-1:0]                      i_virt_addr,
    input  wire logic [PA_W-1:0]                      i_phys_addr,
    input  wire logic [PROT_W-1:0]                    i_prot_bits,
    input  wire logic [PPN_W-1:0]                     i_base_ppn,
    input  wire logic                                 i_clearing,
    output logic                                      o_busy,
    output logic                                      o_done,
    output logic [STATUS_W-1:0]                       o_status,
    output logic [ENTRY_W-1:0]                        o_leaf_entry,
    output logic [PA_W-1:0]                           o_entry_paddr,
    output t_mem_ctl                                  o_mem_ctl,
    output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]      o_mem_addr,
    output logic [ENTRY_W-1:0]                        o_mem_wdata,
    input  wire t_mem_rsp                             i_mem_rsp
);

    localparam int PW = $clog2(TABLE_PAGES);
    localparam int NW = $clog2(TABLE_PAGES + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD_L2  = 8'b0000_0010,
        S_RD_L1  = 8'b0000_0100,
        S_RD_L0  = 8'b0000_1000,
        S_ALLOC  = 8'b0001_0000,
        S_WR_L2  = 8'b0010_0000,
        S_WR_L1  = 8'b0100_0000,
        S_WR_L0  = 8'b1000_0000
    } t_state;

    t_state             r_state,   n_state;
    logic               r_op,      n_op;
    logic [IDX_W-1:0]   r_i2,      n_i2;
    logic [IDX_W-1:0]   r_i1,      n_i1;
    logic [IDX_W-1:0]   r_i0,      n_i0;
    logic [PPN_W-1:0]   r_pa_ppn,  n_pa_ppn;
    logic [PROT_W-1:0]  r_prot,    n_prot;
    logic               r_v2,      n_v2;
    logic               r_v1,      n_v1;
    logic [PW-1:0]      r_p1,      n_p1;
    logic [PW-1:0]      r_p0,      n_p0;
    logic [PW-1:0]      r_rd_page, n_rd_page;
    logic [NW-1:0]      r_nf,      n_nf;
    logic               r_done,    n_done;
    t_status            r_status,  n_status;
    logic [ENTRY_W-1:0] r_leaf,    n_leaf;
    logic [PA_W-1:0]    r_paddr,   n_paddr;

    logic               w_stamp_ok;
    logic [ENTRY_W-1:0] w_entry;
    logic               w_valid;
    logic [PPN_W-1:0]   w_off;
    logic               w_inr;
    logic [PW-1:0]      w_page;
    logic [PPN_W-1:0]   w_nf_ppn;
    logic [PPN_W-1:0]   w_p0_ppn;
    logic [NW-1:0]      w_remaining;
    logic [NW-1:0]      w_need;
    logic [NW-1:0]      w_nf_inc;

    // An entry counts only if its stamp matches whether its page has been taken;
    // a page taken after the write therefore reads as zero.
    assign w_stamp_ok  = i_mem_rsp.stamp == (NW'(r_rd_page) < r_nf);
    assign w_entry     = w_stamp_ok ? i_mem_rsp.data : '0;
    assign w_valid     = w_entry[0];
    assign w_off       = w_entry[PTE_PPN_LSB +: PPN_W] - i_base_ppn;
    assign w_inr       = w_off < PPN_W'(TABLE_PAGES);
    assign w_page      = w_off[PW-1:0];
    assign w_nf_ppn    = i_base_ppn + PPN_W'(r_nf);
    assign w_p0_ppn    = i_base_ppn + PPN_W'(r_p0);
    assign w_remaining = NW'(TABLE_PAGES) - r_nf;
    assign w_need      = !r_v2 ? NW'(2) : (!r_v1 ? NW'(1) : NW'(0));
    assign w_nf_inc    = r_nf + NW'(1);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_i2      = r_i2;
        n_i1      = r_i1;
        n_i0      = r_i0;
        n_pa_ppn  = r_pa_ppn;
        n_prot    = r_prot;
        n_v2      = r_v2;
        n_v1      = r_v1;
        n_p1      = r_p1;
        n_p0      = r_p0;
        n_rd_page = r_rd_page;
        n_nf      = r_nf;
        n_done    = 1'b0;
        n_status  = r_status;
        n_leaf    = r_leaf;
        n_paddr   = r_paddr;
        o_mem_ctl   = '0;
        o_mem_addr  = '0;
        o_mem_wdata = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start && !i_clearing) begin
                    n_op      = i_op;
                    n_i2      = i_virt_addr[30 +: IDX_W];
                    n_i1      = i_virt_addr[21 +: IDX_W];
                    n_i0      = i_virt_addr[PAGE_SHIFT +: IDX_W];
                    n_pa_ppn  = i_phys_addr[PAGE_SHIFT +: PPN_W];
                    n_prot    = i_prot_bits;
                    n_rd_page = '0;
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_addr = {PW'(0), i_virt_addr[30 +: IDX_W]};
                    n_state   = S_RD_L2;
                end
            end
            S_RD_L2: begin
                n_v2 = w_valid;
                n_v1 = 1'b0;
                if (r_op == OP_MAP && !w_valid) begin
                    n_state = S_ALLOC;
                end else if (!w_valid || !w_inr) begin
                    n_done   = 1'b1;
                    n_status = (r_op == OP_LOOKUP) ? ST_NOT_MAPPED : ST_NO_PAGE;
                    n_leaf   = '0;
                    n_paddr  = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_p1      = w_page;
                    n_rd_page = w_page;
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_addr = {w_page, r_i1};
                    n_state   = S_RD_L1;
                end
            end
            S_RD_L1: begin
                n_v1 = w_valid;
                if (w_valid && w_inr) begin
                    n_p0 = w_page;
                end
                if (r_op == OP_MAP && !w_valid) begin
                    n_state = S_ALLOC;
                end else if (!w_valid || !w_inr) begin
                    n_done   = 1'b1;
                    n_status = (r_op == OP_LOOKUP) ? ST_NOT_MAPPED : ST_NO_PAGE;
                    n_leaf   = '0;
                    n_paddr  = '0;
                    n_state  = S_IDLE;
                end else if (r_op == OP_MAP) begin
                    n_state = S_ALLOC;
                end else begin
                    n_rd_page = w_page;
                    o_mem_ctl.rd_en = 1'b1;
                    o_mem_addr = {w_page, r_i0};
                    n_state   = S_RD_L0;
                end
            end
            S_RD_L0: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (!w_valid) begin
                    n_status = ST_NOT_MAPPED;
                    n_leaf   = '0;
                    n_paddr  = '0;
                end else begin
                    n_status = ST_OK;
                    n_leaf   = w_entry;
                    n_paddr  = {w_p0_ppn, r_i0, 3'b000};
                end
            end
            S_ALLOC: begin
                // All or nothing: check room for every page before any write.
                if (w_remaining < w_need) begin
                    n_done   = 1'b1;
                    n_status = ST_NO_PAGE;
                    n_leaf   = '0;
                    n_paddr  = '0;
                    n_state  = S_IDLE;
                end else if (!r_v2) begin
                    n_state = S_WR_L2;
                end else if (!r_v1) begin
                    n_state = S_WR_L1;
                end else begin
                    n_state = S_WR_L0;
                end
            end
            S_WR_L2: begin
                n_p1 = r_nf[PW-1:0];
                n_nf = w_nf_inc;
                o_mem_ctl.wr_en    = 1'b1;
                o_mem_ctl.wr_stamp = 1'b1;
                o_mem_addr  = {PW'(0), r_i2};
                o_mem_wdata = {{(ENTRY_W-PPN_W-PTE_PPN_LSB){1'b0}}, w_nf_ppn,
                               {(PTE_PPN_LSB-1){1'b0}}, 1'b1};
                n_state = S_WR_L1;
            end
            S_WR_L1: begin
                n_p0 = r_nf[PW-1:0];
                n_nf = w_nf_inc;
                o_mem_ctl.wr_en    = 1'b1;
                o_mem_ctl.wr_stamp = NW'(r_p1) < w_nf_inc;
                o_mem_addr  = {r_p1, r_i1};
                o_mem_wdata = {{(ENTRY_W-PPN_W-PTE_PPN_LSB){1'b0}}, w_nf_ppn,
                               {(PTE_PPN_LSB-1){1'b0}}, 1'b1};
                n_state = S_WR_L0;
            end
            S_WR_L0: begin
                o_mem_ctl.wr_en    = 1'b1;
                o_mem_ctl.wr_stamp = NW'(r_p0) < r_nf;
                o_mem_addr  = {r_p0, r_i0};
                o_mem_wdata = {{(ENTRY_W-PPN_W-PTE_PPN_LSB){1'b0}}, r_pa_ppn, r_prot};
                n_done   = 1'b1;
                n_status = ST_OK;
                n_leaf   = {{(ENTRY_W-PPN_W-PTE_PPN_LSB){1'b0}}, r_pa_ppn, r_prot};
                n_paddr  = {w_p0_ppn, r_i0, 3'b000};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nf    <= NW'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nf    <= n_nf;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_i2      <= n_i2;
        r_i1      <= n_i1;
        r_i0      <= n_i0;
        r_pa_ppn  <= n_pa_ppn;
        r_prot    <= n_prot;
        r_v2      <= n_v2;
        r_v1      <= n_v1;
        r_p1      <= n_p1;
        r_p0      <= n_p0;
        r_rd_page <= n_rd_page;
        r_status  <= n_status;
        r_leaf    <= n_leaf;
        r_paddr   <= n_paddr;
    end

    assign o_busy        = (r_state != S_IDLE) || i_clearing;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_leaf_entry  = r_leaf;
    assign o_entry_paddr = r_paddr;

endmodule

`default_nettype wire

// ===== rtl/sv39w_checker.sv =====
// Port-level checks of the walker's command and result behavior, bound to the top level.
// Depends on sv39w_pkg and sv39_map_and_lookup_walker_unit.
`default_nettype none

module sv39w_checker
    import sv39w_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  o_busy,
    input  wire logic                  o_done,
    input  wire logic [STATUS_W-1:0]   o_status,
    input  wire logic [ENTRY_W-1:0]    o_leaf_entry,
    input  wire logic [PA_W-1:0]       o_entry_paddr
);

    // An accepted item keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted item did not raise busy");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without preceding work");

    // Failed requests report zero leaf and zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_leaf_entry == '0 && o_entry_paddr == '0)
        else $error("nonzero payload on failed request");

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_status == ST_OK || o_status == ST_NOT_MAPPED ||
                   o_status == ST_NO_PAGE)
        else $error("undefined status code");

    // Results never come in two consecutive cycles.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

endmodule

bind sv39_map_and_lookup_walker_unit sv39w_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_leaf_entry  (o_leaf_entry),
    .o_entry_paddr (o_entry_paddr)
);

`default_nettype wire
